// ----- hdl/ppd_pkg.sv -----
// Shared types, constants and helper functions for the palette pixel decoder.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package ppd_pkg;

   // Payload widths
   localparam int OP_W       = 2;
   localparam int ID_W       = 32;
   localparam int RGB_W      = 24;
   localparam int RGBA_W     = 32;
   localparam int ADDR_W     = 20;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Id compare limits
   localparam int CHAR_W       = 8;
   localparam int ID_CHARS     = ID_W / CHAR_W;
   localparam int MAX_ID_CHARS = 4;
   localparam int NCHAR_W      = 3;

   // Image geometry
   localparam int MAX_DIM = 1024;
   localparam int DIM_W   = CSR_DATA_W;
   localparam int COL_W   = $clog2(MAX_DIM);
   localparam int ROW_W   = 12;
   localparam int TOTAL_W = 2 * COL_W + 1;

   localparam logic [CHAR_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_START   = 2'd0,
      OP_PALETTE = 2'd1,
      OP_PIXEL   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_UNKNOWN = 3'd2,
      ST_FULL    = 3'd3,
      ST_ABORT   = 3'd4,
      ST_EXCESS  = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ID_CHARS  = 2'd0,
      REG_WIDTH     = 2'd1,
      REG_HEIGHT    = 2'd2,
      REG_TRANSPOSE = 2'd3
   } csr_index_type;

   // Result of a palette lookup
   typedef struct packed {
      logic             hit;
      logic [RGB_W-1:0] color;
   } match_type;

   // Bring a written character count into 1..MAX_ID_CHARS, never past the id width
   function automatic logic [NCHAR_W-1:0] clamp_chars(input logic [NCHAR_W-1:0] n);
      logic [NCHAR_W-1:0] r;
      r = n;
      if (r == '0) begin
         r = NCHAR_W'(1);
      end
      if (r > NCHAR_W'(MAX_ID_CHARS)) begin
         r = NCHAR_W'(MAX_ID_CHARS);
      end
      if (r > NCHAR_W'(ID_CHARS)) begin
         r = NCHAR_W'(ID_CHARS);
      end
      return r;
   endfunction

   // Bring a written dimension into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (r == '0) begin
         r = DIM_W'(1);
      end else if (r > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   // Compare the first n characters; a shared zero character ends the id
   function automatic logic ids_match(input logic [ID_W-1:0] a,
                                      input logic [ID_W-1:0] b,
                                      input logic [NCHAR_W-1:0] n);
      logic              res;
      logic              stop;
      logic [CHAR_W-1:0] ca;
      logic [CHAR_W-1:0] cb;
      res  = 1'b1;
      stop = 1'b0;
      for (int k = 0; k < ID_CHARS; k++) begin
         ca = a[k*CHAR_W +: CHAR_W];
         cb = b[k*CHAR_W +: CHAR_W];
         if (!stop && (NCHAR_W'(k) < n)) begin
            if (ca != cb) begin
               res  = 1'b0;
               stop = 1'b1;
            end else if (ca == '0) begin
               stop = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

// ----- hdl/ppd_req_if.sv -----
// Input item channel of the palette pixel decoder: valid/ready plus payload.
// Depends on ppd_pkg for field widths.
interface ppd_req_if;
   logic                        valid;
   logic                        ready;
   logic [ppd_pkg::OP_W-1:0]    op;
   logic [ppd_pkg::ID_W-1:0]    pixel_id;
   logic [ppd_pkg::RGB_W-1:0]   rgb_color;

   modport source (output valid, output op, output pixel_id, output rgb_color, input ready);
   modport sink   (input valid, input op, input pixel_id, input rgb_color, output ready);
endinterface

// ----- hdl/ppd_rsp_if.sv -----
// Result item channel of the palette pixel decoder: valid/ready plus payload.
// Depends on ppd_pkg for field widths.
interface ppd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ppd_pkg::RGBA_W-1:0]    rgba;
   logic [ppd_pkg::ADDR_W-1:0]    address;
   logic [ppd_pkg::STATUS_W-1:0]  status;
   logic                          last_pixel;

   modport source (output valid, output rgba, output address, output status,
                   output last_pixel, input ready);
   modport sink   (input valid, input rgba, input address, input status,
                   input last_pixel, output ready);
endinterface

// ----- hdl/ppd_csr_if.sv -----
// Register write channel of the palette pixel decoder: valid/ready, index, data.
// Depends on ppd_pkg for field widths.
interface ppd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ppd_pkg::CSR_IDX_W-1:0]   index;
   logic [ppd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ppd_palette.sv -----
// Palette table: id and color storage with a parallel id match over all entries.
// Depends on ppd_pkg (ids_match, match_type, widths).
module ppd_palette #(
   parameter  int MAX_COLORS = 16,
   localparam int IDX_W      = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1,
   localparam int CNT_W      = $clog2(MAX_COLORS + 1)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [IDX_W-1:0]                   wr_idx,
   input  logic [ppd_pkg::ID_W-1:0]           wr_id,
   input  logic [ppd_pkg::RGB_W-1:0]          wr_color,
   input  logic [CNT_W-1:0]                   count,
   input  logic [ppd_pkg::NCHAR_W-1:0]        id_chars,
   input  logic [ppd_pkg::ID_W-1:0]           look_id,
   output ppd_pkg::match_type                 match
);

   logic [ppd_pkg::ID_W-1:0]  ids_ff    [MAX_COLORS];
   logic [ppd_pkg::RGB_W-1:0] colors_ff [MAX_COLORS];
   logic [MAX_COLORS-1:0]     hit_vec;

   // Store a new entry at the fill position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ids_ff[wr_idx]    <= wr_id;
         colors_ff[wr_idx] <= wr_color;
      end
   end

   // Compare every filled entry at once
   always_comb begin
      for (int i = 0; i < MAX_COLORS; i++) begin
         hit_vec[i] = (CNT_W'(i) < count) && ppd_pkg::ids_match(ids_ff[i], look_id, id_chars);
      end
   end

   // Pick the color of the lowest matching entry
   always_comb begin
      match.hit   = |hit_vec;
      match.color = '0;
      for (int i = MAX_COLORS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            match.color = colors_ff[i];
         end
      end
   end

endmodule

// ----- hdl/palette_pixel_decoder.sv -----
// Top level of the palette pixel decoder: register port, input and result stages,
// image position state. Depends on ppd_pkg, ppd_req_if, ppd_rsp_if, ppd_csr_if, ppd_palette.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    op, pixel_id, rgb_color
//   rsp_ch    out        valid/ready    rgba, address, status, last_pixel
//   csr_ch    in         valid/ready    index, data (ready always high)
//
// Every item gives one result; the item is held in the input register and its result in
// the result register. One item per cycle sustained while results are taken, set by the
// single lookup-and-address stage between the input register and the result register
// (one multiplier for the address, one parallel id compare).
// Reset loads config defaults; clears valid flags, image position, fill count, error flag.
// A stalled result holds the result register; the input register keeps accepting
// as long as it can hand its item on in the same cycle.
module palette_pixel_decoder #(
   parameter int MAX_COLORS = 16
) (
   input  logic            clock,
   input  logic            reset,
   ppd_req_if.sink         req_ch,
   ppd_rsp_if.source       rsp_ch,
   ppd_csr_if.sink         csr_ch
);

   localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int CNT_W = $clog2(MAX_COLORS + 1);
   localparam int PROD_W = ppd_pkg::ROW_W + ppd_pkg::DIM_W;

   // Effective configuration
   logic [ppd_pkg::NCHAR_W-1:0]  nchars_ff, nchars_in;
   logic [ppd_pkg::DIM_W-1:0]    width_ff, width_in;
   logic [ppd_pkg::DIM_W-1:0]    height_ff, height_in;
   logic [ppd_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic                         transpose_ff, transpose_in;

   // Input stage
   logic                         in_valid_ff, in_valid_in;
   logic [ppd_pkg::OP_W-1:0]     op_ff, op_in;
   logic [ppd_pkg::ID_W-1:0]     id_ff, id_in;
   logic [ppd_pkg::RGB_W-1:0]    rgb_ff, rgb_in;

   // Image state
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [ppd_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [ppd_pkg::COL_W-1:0]    col_ff, col_in;
   logic [ppd_pkg::TOTAL_W-1:0]  done_ff, done_in;
   logic                         err_ff, err_in;

   // Result stage
   logic                         out_valid_ff, out_valid_in;
   logic [ppd_pkg::RGBA_W-1:0]   rgba_ff, rgba_in;
   logic [ppd_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   ppd_pkg::status_type          status_ff, status_in;
   logic                         last_ff, last_in;

   logic                         advance;
   logic                         pal_wr;
   logic                         csr_wr;
   ppd_pkg::match_type           match;
   logic [ppd_pkg::DIM_W-1:0]    w_new, h_new;
   logic [ppd_pkg::ROW_W-1:0]    mul_a;
   logic [ppd_pkg::DIM_W-1:0]    mul_b;
   logic [ppd_pkg::ROW_W-1:0]    add_c;
   logic [PROD_W-1:0]            addr_full;
   logic [ppd_pkg::TOTAL_W-1:0]  done_next;

   // Register writes: keep clamped values and the pixel total ready for use
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_comb begin
      nchars_in    = nchars_ff;
      transpose_in = transpose_ff;
      w_new        = width_ff;
      h_new        = height_ff;
      if (csr_wr) begin
         case (ppd_pkg::csr_index_type'(csr_ch.index))
            ppd_pkg::REG_ID_CHARS: begin
               nchars_in = ppd_pkg::clamp_chars(csr_ch.data[ppd_pkg::NCHAR_W-1:0]);
            end
            ppd_pkg::REG_WIDTH: begin
               w_new = ppd_pkg::clamp_dim(csr_ch.data);
            end
            ppd_pkg::REG_HEIGHT: begin
               h_new = ppd_pkg::clamp_dim(csr_ch.data);
            end
            ppd_pkg::REG_TRANSPOSE: begin
               transpose_in = csr_ch.data[0];
            end
            default: begin
            end
         endcase
      end
      width_in  = w_new;
      height_in = h_new;
      total_in  = ppd_pkg::TOTAL_W'(w_new * h_new);
   end

   // Input stage: take an item while empty or whenever the held one moves on
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      rgb_in      = rgb_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         op_in       = req_ch.op;
         id_in       = req_ch.pixel_id;
         rgb_in      = req_ch.rgb_color;
      end
   end

   // Palette table
   ppd_palette #(
      .MAX_COLORS (MAX_COLORS)
   ) u_palette (
      .clock    (clock),
      .wr_en    (pal_wr),
      .wr_idx   (count_ff[IDX_W-1:0]),
      .wr_id    (id_ff),
      .wr_color (rgb_ff),
      .count    (count_ff),
      .id_chars (nchars_ff),
      .look_id  (id_ff),
      .match    (match)
   );

   // Destination address: one multiply, operands swapped when transposed
   always_comb begin
      if (transpose_ff) begin
         mul_a = ppd_pkg::ROW_W'(col_ff);
         mul_b = height_ff;
         add_c = row_ff;
      end else begin
         mul_a = row_ff;
         mul_b = width_ff;
         add_c = ppd_pkg::ROW_W'(col_ff);
      end
      addr_full = PROD_W'(mul_a * mul_b) + PROD_W'(add_c);
   end

   assign done_next = done_ff + ppd_pkg::TOTAL_W'(1);

   // Decode the held item and update image state
   always_comb begin
      pal_wr       = 1'b0;
      count_in     = count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff;
      rgba_in      = rgba_ff;
      addr_in      = addr_ff;
      status_in    = status_ff;
      last_in      = last_ff;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         rgba_in      = '0;
         addr_in      = '0;
         status_in    = ppd_pkg::ST_OK;
         last_in      = 1'b0;
         case (ppd_pkg::op_type'(op_ff))
            ppd_pkg::OP_START: begin
               count_in = '0;
               row_in   = '0;
               col_in   = '0;
               done_in  = '0;
               err_in   = 1'b0;
            end
            ppd_pkg::OP_PALETTE: begin
               if (err_ff) begin
                  status_in = ppd_pkg::ST_ABORT;
               end else if (match.hit) begin
                  status_in = ppd_pkg::ST_DUP;
                  err_in    = 1'b1;
               end else if (count_ff == CNT_W'(MAX_COLORS)) begin
                  status_in = ppd_pkg::ST_FULL;
                  err_in    = 1'b1;
               end else begin
                  pal_wr   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ppd_pkg::OP_PIXEL: begin
               if (err_ff) begin
                  status_in = ppd_pkg::ST_ABORT;
               end else if (done_ff >= total_ff) begin
                  status_in = ppd_pkg::ST_EXCESS;
                  err_in    = 1'b1;
               end else if (!match.hit) begin
                  status_in = ppd_pkg::ST_UNKNOWN;
                  err_in    = 1'b1;
               end else begin
                  rgba_in = {match.color, ppd_pkg::ALPHA_OPAQUE};
                  addr_in = addr_full[ppd_pkg::ADDR_W-1:0];
                  done_in = done_next;
                  last_in = (done_next == total_ff);
                  // Wrap to the next row at the end of a row
                  if ((ppd_pkg::DIM_W'(col_ff) + ppd_pkg::DIM_W'(1)) >= width_ff) begin
                     col_in = '0;
                     row_in = row_ff + ppd_pkg::ROW_W'(1);
                  end else begin
                     col_in = col_ff + ppd_pkg::COL_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nchars_ff    <= ppd_pkg::NCHAR_W'(1);
         width_ff     <= ppd_pkg::DIM_W'(64);
         height_ff    <= ppd_pkg::DIM_W'(64);
         total_ff     <= ppd_pkg::TOTAL_W'(4096);
         transpose_ff <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         done_ff      <= '0;
         err_ff       <= 1'b0;
      end else begin
         nchars_ff    <= nchars_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_ff     <= total_in;
         transpose_ff <= transpose_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         done_ff      <= done_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      rgb_ff    <= rgb_in;
      rgba_ff   <= rgba_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.rgba       = rgba_ff;
   assign rsp_ch.address    = addr_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.last_pixel = last_ff;

endmodule

// ----- test/tb_palette_pixel_decoder.sv -----
// Self-checking testbench for palette_pixel_decoder: palette loads, pixel lookups,
// address order and sticky error handling, checked against an in-bench decoder model.
// Depends on ppd_pkg and the ppd_req_if, ppd_rsp_if and ppd_csr_if interfaces.
`timescale 1ns / 100ps

module tb_palette_pixel_decoder;

   localparam int PAL_DEPTH   = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 80;
   localparam logic [ppd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [ppd_pkg::OP_W-1:0]  op;
      logic [ppd_pkg::ID_W-1:0]  id;
      logic [ppd_pkg::RGB_W-1:0] rgb;
   } pixel_item_type;

   typedef struct packed {
      logic [ppd_pkg::RGBA_W-1:0] rgba;
      logic [ppd_pkg::ADDR_W-1:0] address;
      ppd_pkg::status_type        status;
      logic                       last;
   } decoded_type;

   logic clock = 1'b0;
   logic reset;

   ppd_req_if req_ch ();
   ppd_rsp_if rsp_ch ();
   ppd_csr_if csr_ch ();

   // Register copies as last written
   logic [2:0]                     cfg_chars     = 3'd1;
   logic [ppd_pkg::CSR_DATA_W-1:0] cfg_width     = 11'd64;
   logic [ppd_pkg::CSR_DATA_W-1:0] cfg_height    = 11'd64;
   logic                           cfg_transpose = 1'b0;

   // Decoder state mirrored from the item stream
   logic [ppd_pkg::ID_W-1:0]  pal_id  [PAL_DEPTH];
   logic [ppd_pkg::RGB_W-1:0] pal_rgb [PAL_DEPTH];
   int               pal_fill   = 0;
   int unsigned      row_pos    = 0;
   int unsigned      col_pos    = 0;
   int unsigned      pixels_out = 0;
   bit               err_hold   = 1'b0;

   pixel_item_type items_to_send[$];
   pixel_item_type cur_item;
   decoded_type    decoded_due[$];
   decoded_type    seen_want;
   logic [ppd_pkg::ID_W-1:0] frame_ids[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_arm       = 1'b0;
   bit hold_done      = 1'b0;
   int hold_left      = 0;

   int queued_total   = 0;
   int items_in       = 0;
   int results_seen   = 0;
   int pixel_colors   = 0;
   int image_ends     = 0;
   int flagged        = 0;
   int setups         = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   palette_pixel_decoder #(.MAX_COLORS(PAL_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- decoder model

   function automatic int chars_used();
      if (cfg_chars == 3'd0) begin
         return 1;
      end
      if (cfg_chars > ppd_pkg::MAX_ID_CHARS) begin
         return ppd_pkg::MAX_ID_CHARS;
      end
      return int'(cfg_chars);
   endfunction

   function automatic int unsigned fit_dim(input logic [ppd_pkg::CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > ppd_pkg::MAX_DIM) begin
         return ppd_pkg::MAX_DIM;
      end
      return int'(v);
   endfunction

   // Compare characters in order; a zero character shared by both ends the id
   function automatic bit id_equal(input logic [ppd_pkg::ID_W-1:0] a,
                                   input logic [ppd_pkg::ID_W-1:0] b);
      int n;
      n = chars_used();
      for (int k = 0; k < n; k++) begin
         if (a[8*k +: 8] != b[8*k +: 8]) begin
            return 1'b0;
         end
         if (a[8*k +: 8] == 8'h00) begin
            return 1'b1;
         end
      end
      return 1'b1;
   endfunction

   function automatic decoded_type decode_item(input pixel_item_type it);
      decoded_type               r;
      int unsigned               w;
      int unsigned               h;
      int unsigned               total;
      int unsigned               spot;
      logic [ppd_pkg::RGB_W-1:0] hit_rgb;
      bit                        dup;
      bit                        found;
      r.rgba    = '0;
      r.address = '0;
      r.status  = ppd_pkg::ST_OK;
      r.last    = 1'b0;
      w       = fit_dim(cfg_width);
      h       = fit_dim(cfg_height);
      total   = w * h;
      hit_rgb = '0;
      dup     = 1'b0;
      found   = 1'b0;
      case (it.op)
         ppd_pkg::OP_START: begin
            pal_fill   = 0;
            row_pos    = 0;
            col_pos    = 0;
            pixels_out = 0;
            err_hold   = 1'b0;
         end
         ppd_pkg::OP_PALETTE: begin
            if (err_hold) begin
               r.status = ppd_pkg::ST_ABORT;
            end else begin
               for (int i = 0; i < pal_fill; i++) begin
                  if (id_equal(pal_id[i], it.id)) begin
                     dup = 1'b1;
                  end
               end
               // Duplicate wins over a full table
               if (dup) begin
                  r.status = ppd_pkg::ST_DUP;
                  err_hold = 1'b1;
               end else if (pal_fill >= PAL_DEPTH) begin
                  r.status = ppd_pkg::ST_FULL;
                  err_hold = 1'b1;
               end else begin
                  pal_id[pal_fill]  = it.id;
                  pal_rgb[pal_fill] = it.rgb;
                  pal_fill++;
               end
            end
         end
         ppd_pkg::OP_PIXEL: begin
            if (err_hold) begin
               r.status = ppd_pkg::ST_ABORT;
            end else if (pixels_out >= total) begin
               r.status = ppd_pkg::ST_EXCESS;
               err_hold = 1'b1;
            end else begin
               // First matching entry supplies the color
               for (int i = 0; i < pal_fill; i++) begin
                  if (!found && id_equal(it.id, pal_id[i])) begin
                     found   = 1'b1;
                     hit_rgb = pal_rgb[i];
                  end
               end
               if (!found) begin
                  r.status = ppd_pkg::ST_UNKNOWN;
                  err_hold = 1'b1;
               end else begin
                  r.rgba = {hit_rgb, ppd_pkg::ALPHA_OPAQUE};
                  if (cfg_transpose) begin
                     spot = row_pos + col_pos * h;
                  end else begin
                     spot = row_pos * w + col_pos;
                  end
                  r.address = spot[ppd_pkg::ADDR_W-1:0];
                  pixels_out++;
                  r.last = (pixels_out == total);
                  if (col_pos + 1 >= w) begin
                     col_pos = 0;
                     row_pos = (row_pos + 1) & 32'hFFF;
                  end else begin
                     col_pos++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus builders

   task automatic queue_item(input logic [ppd_pkg::OP_W-1:0] op,
                             input logic [ppd_pkg::ID_W-1:0] id,
                             input logic [ppd_pkg::RGB_W-1:0] rgb);
      pixel_item_type it;
      it.op  = op;
      it.id  = id;
      it.rgb = rgb;
      items_to_send.push_back(it);
      queued_total++;
   endtask

   // Randomize every byte the compare never reaches
   function automatic logic [ppd_pkg::ID_W-1:0] blur_tail(input logic [ppd_pkg::ID_W-1:0] id);
      logic [ppd_pkg::ID_W-1:0] r;
      int              n;
      int              from;
      r    = id;
      n    = chars_used();
      from = n;
      for (int k = n - 1; k >= 0; k--) begin
         if (id[8*k +: 8] == 8'h00) begin
            from = k + 1;
         end
      end
      for (int k = from; k < ppd_pkg::ID_CHARS; k++) begin
         r[8*k +: 8] = 8'($urandom_range(0, 255));
      end
      return r;
   endfunction

   // Draw an id, trying for one that matches none already in this image's palette
   function automatic logic [ppd_pkg::ID_W-1:0] fresh_id();
      logic [ppd_pkg::ID_W-1:0] c;
      bit              clash;
      int              k;
      c = '0;
      for (int t = 0; t < 64; t++) begin
         c = $urandom;
         if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, ppd_pkg::ID_CHARS - 1);
            c[8*k +: 8] = 8'h00;
         end
         clash = 1'b0;
         foreach (frame_ids[j]) begin
            if (id_equal(frame_ids[j], c)) begin
               clash = 1'b1;
            end
         end
         if (!clash) begin
            return c;
         end
      end
      return c;
   endfunction

   task automatic queue_palette(input int n, input bit allow_dup);
      logic [ppd_pkg::ID_W-1:0] id;
      frame_ids.delete();
      queue_item(ppd_pkg::OP_START, $urandom, 24'($urandom));
      for (int i = 0; i < n; i++) begin
         id = fresh_id();
         frame_ids.push_back(id);
         queue_item(ppd_pkg::OP_PALETTE, id, 24'($urandom));
      end
      if (allow_dup && $urandom_range(0, 11) == 0) begin
         id = blur_tail(frame_ids[$urandom_range(0, frame_ids.size() - 1)]);
         queue_item(ppd_pkg::OP_PALETTE, id, 24'($urandom));
      end
   endtask

   task automatic queue_pixels(input int n, input int miss_pct);
      logic [ppd_pkg::ID_W-1:0] id;
      for (int i = 0; i < n; i++) begin
         if (frame_ids.size() == 0 || $urandom_range(0, 99) < miss_pct) begin
            id = $urandom;
         end else begin
            id = blur_tail(frame_ids[$urandom_range(0, frame_ids.size() - 1)]);
         end
         queue_item(ppd_pkg::OP_PIXEL, id, 24'($urandom));
      end
   endtask

   // One image: start, palette, then pixels up to, short of or past the end
   task automatic queue_frame();
      int roll;
      int n_pal;
      int n_pix;
      int total;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         n_pal = PAL_DEPTH + 1;
      end else if (roll == 1) begin
         n_pal = PAL_DEPTH;
      end else begin
         n_pal = $urandom_range(1, 6);
      end
      queue_palette(n_pal, 1'b1);
      total = fit_dim(cfg_width) * fit_dim(cfg_height);
      if (total <= 48) begin
         roll = $urandom_range(0, 19);
         if (roll < 10) begin
            n_pix = total;
         end else if (roll < 14) begin
            n_pix = total + 1;
         end else begin
            n_pix = $urandom_range(1, total);
         end
      end else begin
         n_pix = $urandom_range(1, 24);
      end
      queue_pixels(n_pix, 4);
   endtask

   task automatic queue_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         queue_item(ppd_pkg::OP_W'($urandom_range(0, 3)), $urandom, 24'($urandom));
      end
   endtask

   task automatic fill_random(input int n);
      int target;
      target = queued_total + n;
      while (queued_total < target) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_noise();
         end else begin
            queue_frame();
         end
      end
   endtask

   // ---------------------------------------------------------------- phase control

   task automatic write_reg(input ppd_pkg::csr_index_type idx,
                            input logic [ppd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!(csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         @(posedge clock);
      end
      case (idx)
         ppd_pkg::REG_ID_CHARS:  cfg_chars     = value[2:0];
         ppd_pkg::REG_WIDTH:     cfg_width     = value;
         ppd_pkg::REG_HEIGHT:    cfg_height    = value;
         ppd_pkg::REG_TRANSPOSE: cfg_transpose = value[0];
         default: begin
         end
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   // Hold until every queued item is in and every result is back
   task automatic drain_all();
      @(posedge clock);
      while (items_to_send.size() != 0 || req_ch.valid !== 1'b0 || decoded_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic setup_phase(input int chars, input int w, input int h, input int tr,
                              input idle_mode_type mode);
      drain_all();
      write_reg(ppd_pkg::REG_ID_CHARS, ppd_pkg::CSR_DATA_W'(chars));
      write_reg(ppd_pkg::REG_WIDTH, ppd_pkg::CSR_DATA_W'(w));
      write_reg(ppd_pkg::REG_HEIGHT, ppd_pkg::CSR_DATA_W'(h));
      write_reg(ppd_pkg::REG_TRANSPOSE, ppd_pkg::CSR_DATA_W'(tr));
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct  = 71;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct  = 0;
            recv_stall_pct = 71;
         end
         default: begin
            send_idle_pct  = 15;
            recv_stall_pct = 15;
         end
      endcase
      setups++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // Predict the item taken at this edge
         if (req_ch.valid && req_ch.ready) begin
            decoded_due.push_back(decode_item(cur_item));
            items_in++;
         end
         // Offer the next item or drop valid
         if (!req_ch.valid || req_ch.ready) begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_item = items_to_send.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.op        <= cur_item.op;
               req_ch.pixel_id  <= cur_item.id;
               req_ch.rgb_color <= cur_item.rgb;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- long hold-off

   // Count the one long receiver hold-off once it is armed
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (decoded_due.size() == 0) begin
               $error("result with no item outstanding: status %0d", rsp_ch.status);
               fail_count++;
            end else begin
               seen_want = decoded_due.pop_front();
               results_seen++;
               if (rsp_ch.rgba !== seen_want.rgba) begin
                  $error("rgba: expected %h, got %h", seen_want.rgba, rsp_ch.rgba);
                  fail_count++;
               end
               if (rsp_ch.address !== seen_want.address) begin
                  $error("address: expected %0d, got %0d", seen_want.address, rsp_ch.address);
                  fail_count++;
               end
               if (rsp_ch.status !== seen_want.status) begin
                  $error("status: expected %0d, got %0d", seen_want.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.last_pixel !== seen_want.last) begin
                  $error("last_pixel: expected %0d, got %0d", seen_want.last, rsp_ch.last_pixel);
                  fail_count++;
               end
               if (seen_want.rgba[7:0] == ppd_pkg::ALPHA_OPAQUE) begin
                  pixel_colors++;
               end
               if (seen_want.last) begin
                  image_ends++;
               end
               if (seen_want.status != ppd_pkg::ST_OK) begin
                  flagged++;
               end
            end
         end
         // Hold off while the long stretch runs, else random stalls
         if (hold_left != 0 || (hold_arm && !hold_done)) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, decoded_due.size());
         $display("tb_palette_pixel_decoder: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = ppd_pkg::OP_START;
      req_ch.pixel_id  = '0;
      req_ch.rgb_color = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = ppd_pkg::REG_ID_CHARS;
      csr_ch.data      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Two-char ids, zero width, transposed: unused op, zero-ended ids,
      // image end, excess pixel, aborts, unknown id
      setup_phase(2, 0, 2, 1, IDLE_NONE);
      queue_item(OP_UNUSED, 32'hFFFF_FFFF, 24'hFF_FFFF);
      queue_item(ppd_pkg::OP_START, 32'h0, 24'h0);
      queue_item(ppd_pkg::OP_PALETTE, 32'h0000_4241, 24'hFF_FFFF);
      queue_item(ppd_pkg::OP_PALETTE, 32'hFFFF_4341, 24'h00_0000);
      queue_item(ppd_pkg::OP_PALETTE, 32'h0000_0000, 24'h12_3456);
      queue_item(ppd_pkg::OP_PIXEL, 32'h1234_4241, 24'h0);
      queue_item(ppd_pkg::OP_PIXEL, 32'hABCD_0000, 24'hFF_FFFF);
      queue_item(ppd_pkg::OP_PIXEL, 32'h0000_4341, 24'h0);
      queue_item(ppd_pkg::OP_PIXEL, 32'h0000_4241, 24'h0);
      queue_item(ppd_pkg::OP_PALETTE, 32'h0000_4441, 24'h0);
      queue_item(ppd_pkg::OP_START, 32'hFFFF_FFFF, 24'hFF_FFFF);
      queue_item(ppd_pkg::OP_PALETTE, 32'hFFFF_FFFF, 24'hAA_AAAA);
      queue_item(ppd_pkg::OP_PIXEL, 32'h0000_FF41, 24'h0);
      queue_item(ppd_pkg::OP_PIXEL, 32'hFFFF_FFFF, 24'h0);

      // Char count past the limit, oversized width: zero-stop duplicate, four-char ids
      setup_phase(7, 2047, 1, 0, IDLE_NONE);
      queue_item(ppd_pkg::OP_START, 32'h0, 24'h0);
      queue_item(ppd_pkg::OP_PALETTE, 32'h0000_0041, 24'h0F_0F0F);
      queue_item(ppd_pkg::OP_PALETTE, 32'h5500_0041, 24'h0);
      queue_item(ppd_pkg::OP_START, 32'h0, 24'h0);
      queue_item(ppd_pkg::OP_PALETTE, 32'h4443_4241, 24'hF0_F0F0);
      queue_item(ppd_pkg::OP_PALETTE, 32'h4543_4241, 24'h00_FF00);
      queue_item(ppd_pkg::OP_PIXEL, 32'h4543_4241, 24'h0);
      queue_item(ppd_pkg::OP_PIXEL, 32'h4443_4241, 24'h0);
      queue_item(ppd_pkg::OP_PIXEL, 32'h4643_4241, 24'h0);
      queue_item(ppd_pkg::OP_START, 32'h0, 24'h0);
      queue_item(OP_UNUSED, 32'h0, 24'h0);

      // Random images over a spread of settings and idle patterns
      setup_phase(0, 3, 2, 0, IDLE_NONE);
      fill_random(170);
      setup_phase(4, 5, 3, 1, IDLE_SEND);
      fill_random(170);
      setup_phase(1, 1, 1, 0, IDLE_RECV);
      fill_random(140);
      setup_phase(3, 4, 4, 1, IDLE_BOTH);
      fill_random(170);

      // One tall narrow image run deep, receiver held off long at its start
      setup_phase(2, 1, 1024, 0, IDLE_NONE);
      queue_palette(4, 1'b0);
      queue_pixels(620, 0);
      hold_arm = 1'b1;

      // Same image continued at full size, raster then transposed
      setup_phase(2, 2047, 2047, 0, IDLE_BOTH);
      queue_pixels(10, 0);
      setup_phase(2, 2047, 1024, 1, IDLE_SEND);
      queue_pixels(10, 0);

      setup_phase(7, 0, 0, 1, IDLE_RECV);
      fill_random(120);
      setup_phase(1, 2047, 1, 1, IDLE_BOTH);
      fill_random(150);
      setup_phase(4, 6, 7, 0, IDLE_NONE);
      fill_random(150);
      setup_phase(3, 8, 3, 1, IDLE_RECV);
      fill_random(150);

      drain_all();
      repeat (8) @(posedge clock);

      $display("covered %0d items in %0d register setups; %0d results checked",
               items_in, setups, results_seen);
      $display("%0d pixels colored, %0d images completed, %0d items flagged",
               pixel_colors, image_ends, flagged);
      if (fail_count == 0) begin
         $display("tb_palette_pixel_decoder: done, clean");
      end else begin
         $display("tb_palette_pixel_decoder: done, errors");
      end
      $finish;
   end

endmodule
